FILE: design/c2p_pkg.sv
`timescale 1ns / 1ps

package c2p_pkg;

  localparam int XY_W         = 64;
  localparam int ZW           = 27;
  localparam int PHASE_W      = 17;
  localparam int MAG_W        = 16;
  localparam int CORDIC_STEPS = 22;
  localparam int CORDIC_BASE  = 60;

  localparam logic signed [ZW-1:0]      DEG180_Q16 = 27'sd11796480;
  localparam logic signed [ZW-1:0]      ROUND_Q8   = 27'sd128;
  localparam logic signed [PHASE_W-1:0] PHASE_LIM  = 17'sd46080;
  localparam logic signed [PHASE_W-1:0] DEG90_Q8   = 17'sd23040;

  typedef struct packed {
    logic                      special;
    logic signed [PHASE_W-1:0] spec_phase;
  } c2p_ctl_t;

  function automatic logic [ZW-1:0] atan_q16(input int unsigned idx);
    logic [ZW-1:0] v;
    case (idx)
      0:       v = 27'd2949120;
      1:       v = 27'd1740967;
      2:       v = 27'd919879;
      3:       v = 27'd466945;
      4:       v = 27'd234379;
      5:       v = 27'd117304;
      6:       v = 27'd58666;
      7:       v = 27'd29335;
      8:       v = 27'd14668;
      9:       v = 27'd7334;
      10:      v = 27'd3667;
      11:      v = 27'd1833;
      12:      v = 27'd917;
      13:      v = 27'd458;
      14:      v = 27'd229;
      15:      v = 27'd115;
      16:      v = 27'd57;
      17:      v = 27'd29;
      18:      v = 27'd14;
      19:      v = 27'd7;
      20:      v = 27'd4;
      21:      v = 27'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/c2p_if.sv
`timescale 1ns / 1ps

interface c2p_in_if #(parameter int SW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] real_part;
  logic signed [SW-1:0] imag_part;

  modport source (output valid, output real_part, output imag_part, input ready);
  modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

interface c2p_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] magnitude;
  logic signed [16:0] phase_deg_q8;

  modport source (output valid, output magnitude, output phase_deg_q8, input ready);
  modport sink   (input valid, input magnitude, input phase_deg_q8, output ready);
endinterface

FILE: design/c2p_front.sv
`timescale 1ns / 1ps

module c2p_front #(
  parameter int SW = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en1,
  input  logic                                  en2,
  input  logic                                  valid_i,
  input  logic signed [SW-1:0]                  real_part,
  input  logic signed [SW-1:0]                  imag_part,
  output logic                                  valid1_o,
  output logic                                  valid2_o,
  output logic signed [c2p_pkg::XY_W-1:0]       x_o,
  output logic signed [c2p_pkg::XY_W-1:0]       y_o,
  output logic signed [c2p_pkg::ZW-1:0]         z_o,
  output c2p_pkg::c2p_ctl_t                     ctl_o,
  output logic        [2*SW-1:0]                s_o
);
  import c2p_pkg::*;

  localparam int CSHIFT = CORDIC_BASE - SW;

  logic                   neg;
  logic                   im_pos;
  logic        [SW-1:0]   are;
  logic        [SW-1:0]   aim;
  logic signed [XY_W-1:0] xe;
  logic signed [XY_W-1:0] ye;

  logic                   valid1_r;
  logic signed [XY_W-1:0] x1_r, x1_nxt;
  logic signed [XY_W-1:0] y1_r, y1_nxt;
  logic signed [ZW-1:0]   z1_r, z1_nxt;
  c2p_ctl_t               ctl1_r, ctl1_nxt;
  logic        [2*SW-1:0] sqa_r, sqa_nxt;
  logic        [2*SW-1:0] sqb_r, sqb_nxt;

  logic                   valid2_r;
  logic signed [XY_W-1:0] x2_r;
  logic signed [XY_W-1:0] y2_r;
  logic signed [ZW-1:0]   z2_r;
  c2p_ctl_t               ctl2_r;
  logic        [2*SW-1:0] s_r, s_nxt;

  // Left half plane samples are turned by 180 degrees so the rotations converge.
  always_comb begin
    neg    = real_part[SW-1];
    im_pos = !imag_part[SW-1] && (imag_part != '0);
    are    = real_part[SW-1] ? $unsigned(-real_part) : $unsigned(real_part);
    aim    = imag_part[SW-1] ? $unsigned(-imag_part) : $unsigned(imag_part);
    xe     = XY_W'(real_part);
    ye     = XY_W'(imag_part);
    x1_nxt = (neg ? -xe : xe) <<< CSHIFT;
    y1_nxt = (neg ? -ye : ye) <<< CSHIFT;
    z1_nxt = neg ? (im_pos ? DEG180_Q16 : -DEG180_Q16) : '0;
    sqa_nxt = are * are;
    sqb_nxt = aim * aim;
    ctl1_nxt.special    = 1'b0;
    ctl1_nxt.spec_phase = '0;
    if (imag_part == '0) begin
      ctl1_nxt.special    = 1'b1;
      ctl1_nxt.spec_phase = neg ? PHASE_LIM : '0;
    end else if (real_part == '0) begin
      ctl1_nxt.special    = 1'b1;
      ctl1_nxt.spec_phase = im_pos ? DEG90_Q8 : -DEG90_Q8;
    end
  end

  assign s_nxt = sqa_r + sqb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      if (en1) begin
        valid1_r <= valid_i;
      end
      if (en2) begin
        valid2_r <= valid1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      x1_r   <= x1_nxt;
      y1_r   <= y1_nxt;
      z1_r   <= z1_nxt;
      ctl1_r <= ctl1_nxt;
      sqa_r  <= sqa_nxt;
      sqb_r  <= sqb_nxt;
    end
    if (en2) begin
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      z2_r   <= z1_r;
      ctl2_r <= ctl1_r;
      s_r    <= s_nxt;
    end
  end

  assign valid1_o = valid1_r;
  assign valid2_o = valid2_r;
  assign x_o      = x2_r;
  assign y_o      = y2_r;
  assign z_o      = z2_r;
  assign ctl_o    = ctl2_r;
  assign s_o      = s_r;

endmodule

FILE: design/c2p_step.sv
`timescale 1ns / 1ps

module c2p_step #(
  parameter int SW   = 16,
  parameter int STEP = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            valid_i,
  input  logic signed [c2p_pkg::XY_W-1:0] x_i,
  input  logic signed [c2p_pkg::XY_W-1:0] y_i,
  input  logic signed [c2p_pkg::ZW-1:0]   z_i,
  input  c2p_pkg::c2p_ctl_t               ctl_i,
  input  logic        [2*SW-1:0]          s_i,
  input  logic        [SW-1:0]            root_i,
  input  logic        [SW+1:0]            rem_i,
  output logic                            valid_o,
  output logic signed [c2p_pkg::XY_W-1:0] x_o,
  output logic signed [c2p_pkg::XY_W-1:0] y_o,
  output logic signed [c2p_pkg::ZW-1:0]   z_o,
  output c2p_pkg::c2p_ctl_t               ctl_o,
  output logic        [2*SW-1:0]          s_o,
  output logic        [SW-1:0]            root_o,
  output logic        [SW+1:0]            rem_o
);
  import c2p_pkg::*;

  localparam bit DO_ROT  = STEP < CORDIC_STEPS;
  localparam bit DO_SQRT = STEP < SW;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [ZW-1:0]   da;
  logic        [SW+1:0]   rem_sh;
  logic        [SW+1:0]   trial;
  logic                   take;

  logic                   valid_r;
  logic signed [XY_W-1:0] x_r, x_nxt;
  logic signed [XY_W-1:0] y_r, y_nxt;
  logic signed [ZW-1:0]   z_r, z_nxt;
  c2p_ctl_t               ctl_r;
  logic        [2*SW-1:0] s_r, s_nxt;
  logic        [SW-1:0]   root_r, root_nxt;
  logic        [SW+1:0]   rem_r, rem_nxt;

  always_comb begin
    dx    = y_i >>> STEP;
    dy    = x_i >>> STEP;
    da    = $signed(atan_q16(STEP));
    x_nxt = x_i;
    y_nxt = y_i;
    z_nxt = z_i;
    if (DO_ROT) begin
      if (y_i > 0) begin
        x_nxt = x_i + dx;
        y_nxt = y_i - dy;
        z_nxt = z_i + da;
      end else begin
        x_nxt = x_i - dx;
        y_nxt = y_i + dy;
        z_nxt = z_i - da;
      end
    end
  end

  // One result bit of the square root per step, two radicand bits consumed.
  always_comb begin
    rem_sh   = {rem_i[SW-1:0], s_i[2*SW-1 -: 2]};
    trial    = {root_i, 2'b01};
    take     = rem_sh >= trial;
    s_nxt    = s_i;
    root_nxt = root_i;
    rem_nxt  = rem_i;
    if (DO_SQRT) begin
      s_nxt    = {s_i[2*SW-3:0], 2'b00};
      root_nxt = {root_i[SW-2:0], take};
      rem_nxt  = take ? (rem_sh - trial) : rem_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      ctl_r  <= ctl_i;
      s_r    <= s_nxt;
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign ctl_o   = ctl_r;
  assign s_o     = s_r;
  assign root_o  = root_r;
  assign rem_o   = rem_r;

endmodule

FILE: design/c2p_back.sv
`timescale 1ns / 1ps

module c2p_back #(
  parameter int SW = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               valid_i,
  input  logic signed [c2p_pkg::ZW-1:0]      z_i,
  input  c2p_pkg::c2p_ctl_t                  ctl_i,
  input  logic        [SW-1:0]               root_i,
  input  logic        [SW+1:0]               rem_i,
  output logic                               valid_o,
  output logic        [c2p_pkg::MAG_W-1:0]   magnitude,
  output logic signed [c2p_pkg::PHASE_W-1:0] phase_deg_q8
);
  import c2p_pkg::*;

  logic                      round_up;
  logic        [SW:0]        mag_full;
  logic        [SW+MAG_W:0]  mag_ext;
  logic signed [ZW-1:0]      z_rnd;
  logic signed [ZW-1:0]      q;
  logic signed [ZW-1:0]      lim;

  logic                      valid_r;
  logic        [MAG_W-1:0]   mag_r, mag_nxt;
  logic signed [PHASE_W-1:0] phase_r, phase_nxt;

  // The remainder after the root steps is s - r*r, so r+1 is nearer when it exceeds r.
  always_comb begin
    round_up  = rem_i > {2'b00, root_i};
    mag_full  = {1'b0, root_i} + (SW+1)'(round_up);
    mag_ext   = {{MAG_W{1'b0}}, mag_full};
    mag_nxt   = mag_ext[MAG_W-1:0];
    lim       = ZW'(PHASE_LIM);
    z_rnd     = z_i + ROUND_Q8;
    q         = z_rnd >>> 8;
    if (q > lim) begin
      q = lim;
    end else if (q < -lim) begin
      q = -lim;
    end
    phase_nxt = ctl_i.special ? ctl_i.spec_phase : $signed(q[PHASE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= mag_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign valid_o      = valid_r;
  assign magnitude    = mag_r;
  assign phase_deg_q8 = phase_r;

endmodule

FILE: design/cartesian_to_polar_degrees.sv
`timescale 1ns / 1ps
// An accepted word passes the front stages, every step stage and the back stage to its result.
// One word per cycle unless stalled; a stage does one CORDIC rotation and one root bit if due.
// A stalled output holds only the stages behind it that are full, so bubbles still fill.
// Reset: synchronous, active low; it clears every stage valid bit, payload is not reset.
module cartesian_to_polar_degrees #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  c2p_in_if.sink           in_if,
  c2p_out_if.source        out_if
);
  import c2p_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int NSTEP = (SW > CORDIC_STEPS) ? SW : CORDIC_STEPS;
  localparam int NLAST = NSTEP + 2;

  logic [NLAST:0] vld;
  logic [NLAST:0] en;

  logic signed [XY_W-1:0] x_c    [NSTEP+1];
  logic signed [XY_W-1:0] y_c    [NSTEP+1];
  logic signed [ZW-1:0]   z_c    [NSTEP+1];
  c2p_ctl_t               ctl_c  [NSTEP+1];
  logic        [2*SW-1:0] s_c    [NSTEP+1];
  logic        [SW-1:0]   root_c [NSTEP+1];
  logic        [SW+1:0]   rem_c  [NSTEP+1];

  assign en[NLAST] = !vld[NLAST] || out_if.ready;

  genvar k;
  generate
    for (k = 0; k < NLAST; k++) begin : g_en
      assign en[k] = !vld[k] || en[k+1];
    end
  endgenerate

  assign in_if.ready = en[0];

  c2p_front #(
    .SW (SW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en1       (en[0]),
    .en2       (en[1]),
    .valid_i   (in_if.valid),
    .real_part (in_if.real_part),
    .imag_part (in_if.imag_part),
    .valid1_o  (vld[0]),
    .valid2_o  (vld[1]),
    .x_o       (x_c[0]),
    .y_o       (y_c[0]),
    .z_o       (z_c[0]),
    .ctl_o     (ctl_c[0]),
    .s_o       (s_c[0])
  );

  assign root_c[0] = '0;
  assign rem_c[0]  = '0;

  generate
    for (k = 0; k < NSTEP; k++) begin : g_step
      c2p_step #(
        .SW   (SW),
        .STEP (k)
      ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en[k+2]),
        .valid_i (vld[k+1]),
        .x_i     (x_c[k]),
        .y_i     (y_c[k]),
        .z_i     (z_c[k]),
        .ctl_i   (ctl_c[k]),
        .s_i     (s_c[k]),
        .root_i  (root_c[k]),
        .rem_i   (rem_c[k]),
        .valid_o (vld[k+2]),
        .x_o     (x_c[k+1]),
        .y_o     (y_c[k+1]),
        .z_o     (z_c[k+1]),
        .ctl_o   (ctl_c[k+1]),
        .s_o     (s_c[k+1]),
        .root_o  (root_c[k+1]),
        .rem_o   (rem_c[k+1])
      );
    end
  endgenerate

  c2p_back #(
    .SW (SW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en[NLAST]),
    .valid_i      (vld[NLAST-1]),
    .z_i          (z_c[NSTEP]),
    .ctl_i        (ctl_c[NSTEP]),
    .root_i       (root_c[NSTEP]),
    .rem_i        (rem_c[NSTEP]),
    .valid_o      (vld[NLAST]),
    .magnitude    (out_if.magnitude),
    .phase_deg_q8 (out_if.phase_deg_q8)
  );

  assign out_if.valid = vld[NLAST];

  // An accepted word always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> vld[0])
    else $error("accepted word did not enter the first stage");

  // With every stage full and the output stalled, nothing new may be taken.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((&vld) && !out_if.ready) |-> !in_if.ready)
    else $error("input taken while the pipeline was full and stalled");

  // The phase never leaves the half-turn range.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.phase_deg_q8 <= PHASE_LIM && out_if.phase_deg_q8 >= -PHASE_LIM))
    else $error("phase outside +-180 degrees");

endmodule
